@@ sv/eavr_pkg.sv @@
// euler_angle_vector_rotation shared package: payload types, cordic constants, helpers
// no dependencies
package eavr_pkg;

    localparam int VECTOR_WIDTH = 24;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int ZW = 34;   // cordic angle accumulator, 2^30 units
    localparam int XW = 34;   // cordic x/y datapath
    localparam int TW = 16;   // q1.14 trig word
    localparam int MW = 18;   // matrix entry
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic OP_BODY  = 1'b0;
    localparam logic OP_EARTH = 1'b1;

    localparam logic signed [ZW-1:0] ANG_PI      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic                           op;
        logic signed [VECTOR_WIDTH-1:0] vec_x;
        logic signed [VECTOR_WIDTH-1:0] vec_y;
        logic signed [VECTOR_WIDTH-1:0] vec_z;
        logic signed [ANGLE_WIDTH-1:0]  angle_x;
        logic signed [ANGLE_WIDTH-1:0]  angle_y;
        logic signed [ANGLE_WIDTH-1:0]  angle_z;
    } in_item_t;

    typedef struct packed {
        logic signed [VECTOR_WIDTH-1:0] out_x;
        logic signed [VECTOR_WIDTH-1:0] out_y;
        logic signed [VECTOR_WIDTH-1:0] out_z;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                           op;
        logic signed [VECTOR_WIDTH-1:0] vec_x;
        logic signed [VECTOR_WIDTH-1:0] vec_y;
        logic signed [VECTOR_WIDTH-1:0] vec_z;
        logic signed [TW-1:0]           sx;
        logic signed [TW-1:0]           cx;
        logic signed [TW-1:0]           sy;
        logic signed [TW-1:0]           cy;
        logic signed [TW-1:0]           sz;
        logic signed [TW-1:0]           cz;
    } trig_item_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic push;
        logic pop;
    } q_status_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0:  r = 34'sd843314856;
                1:  r = 34'sd497837829;
                2:  r = 34'sd263043836;
                3:  r = 34'sd133525158;
                4:  r = 34'sd67021686;
                5:  r = 34'sd33543515;
                6:  r = 34'sd16775850;
                7:  r = 34'sd8388437;
                8:  r = 34'sd4194282;
                9:  r = 34'sd2097149;
                10: r = 34'sd1048575;
                11: r = 34'sd524287;
                12: r = 34'sd262143;
                13: r = 34'sd131071;
                14: r = 34'sd65535;
                15: r = 34'sd32767;
                16: r = 34'sd16383;
                17: r = 34'sd8191;
                18: r = 34'sd4095;
                19: r = 34'sd2047;
                20: r = 34'sd1023;
                21: r = 34'sd511;
                22: r = 34'sd255;
                23: r = 34'sd127;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // round half up of x / 2^16, clamp to +-1.0 in q1.14
    function automatic logic signed [TW-1:0] to_q14(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        begin
            r = (v + XW'(32768)) >>> 16;
            if (r > XW'(16384))
                r = XW'(16384);
            else if (r < -XW'(16384))
                r = -XW'(16384);
            return r[TW-1:0];
        end
    endfunction

endpackage

@@ sv/eavr_front.sv @@
// front: pipelined cordic sine/cosine of the three angles, one stage per rotation
// depends on eavr_pkg
module eavr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  eavr_pkg::in_item_t    in_item,
    output logic                  out_valid,
    output eavr_pkg::trig_item_t  out_item
);
    import eavr_pkg::*;

    localparam int NS = CORDIC_STEPS + 1;

    logic                           v_reg   [NS+1];
    logic                           op_reg  [NS+1];
    logic signed [VECTOR_WIDTH-1:0] vx_reg  [NS+1];
    logic signed [VECTOR_WIDTH-1:0] vy_reg  [NS+1];
    logic signed [VECTOR_WIDTH-1:0] vz_reg  [NS+1];
    logic signed [XW-1:0]           x_reg   [NS+1][3];
    logic signed [XW-1:0]           y_reg   [NS+1][3];
    logic signed [ZW-1:0]           z_reg   [NS+1][3];
    logic                           neg_reg [NS+1][3];

    logic signed [ANGLE_WIDTH-1:0] ang [3];
    assign ang[0] = in_item.angle_x;
    assign ang[1] = in_item.angle_y;
    assign ang[2] = in_item.angle_z;

    // stage 0: scale to 2^30 units and fold into +-pi/2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        logic signed [ZW-1:0] z;
        op_reg[0] <= in_item.op;
        vx_reg[0] <= in_item.vec_x;
        vy_reg[0] <= in_item.vec_y;
        vz_reg[0] <= in_item.vec_z;
        for (int k = 0; k < 3; k++)
        begin
            z = ZW'(ang[k]) <<< (30 - (ANGLE_WIDTH - 3));
            x_reg[0][k] <= CORDIC_GAIN;
            y_reg[0][k] <= '0;
            if (z > ANG_HALF_PI)
            begin
                z_reg[0][k]   <= z - ANG_PI;
                neg_reg[0][k] <= 1'b1;
            end
            else if (z < -ANG_HALF_PI)
            begin
                z_reg[0][k]   <= z + ANG_PI;
                neg_reg[0][k] <= 1'b1;
            end
            else
            begin
                z_reg[0][k]   <= z;
                neg_reg[0][k] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            op_reg[i+1] <= op_reg[i];
            vx_reg[i+1] <= vx_reg[i];
            vy_reg[i+1] <= vy_reg[i];
            vz_reg[i+1] <= vz_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[i+1][k] <= neg_reg[i][k];
                if (!z_reg[i][k][ZW-1])
                begin
                    x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                    y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                    z_reg[i+1][k] <= z_reg[i][k] - atan_entry(i);
                end
                else
                begin
                    x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                    y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                    z_reg[i+1][k] <= z_reg[i][k] + atan_entry(i);
                end
            end
        end
    end

    // final stage: round, clamp, restore sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[NS] <= 1'b0;
        else
            v_reg[NS] <= v_reg[NS-1];
    end

    logic signed [TW-1:0] s_reg [3];
    logic signed [TW-1:0] c_reg [3];

    always_ff @(posedge clk)
    begin
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
        op_reg[NS] <= op_reg[NS-1];
        vx_reg[NS] <= vx_reg[NS-1];
        vy_reg[NS] <= vy_reg[NS-1];
        vz_reg[NS] <= vz_reg[NS-1];
        for (int k = 0; k < 3; k++)
        begin
            c = to_q14(x_reg[NS-1][k]);
            s = to_q14(y_reg[NS-1][k]);
            c_reg[k] <= neg_reg[NS-1][k] ? -c : c;
            s_reg[k] <= neg_reg[NS-1][k] ? -s : s;
        end
    end

    assign out_valid      = v_reg[NS];
    assign out_item.op    = op_reg[NS];
    assign out_item.vec_x = vx_reg[NS];
    assign out_item.vec_y = vy_reg[NS];
    assign out_item.vec_z = vz_reg[NS];
    assign out_item.sx    = s_reg[0];
    assign out_item.cx    = c_reg[0];
    assign out_item.sy    = s_reg[1];
    assign out_item.cy    = c_reg[1];
    assign out_item.sz    = s_reg[2];
    assign out_item.cz    = c_reg[2];

endmodule

@@ sv/eavr_queue.sv @@
// short fifo between the trig front and the matrix back
// depends on eavr_pkg
module eavr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  eavr_pkg::trig_item_t  push_item,
    input  logic                  pop,
    output eavr_pkg::trig_item_t  pop_item,
    output eavr_pkg::q_status_t   status
);
    import eavr_pkg::*;

    trig_item_t      mem_reg [QDEPTH];
    logic [QAW-1:0]  wr_reg, wr_next;
    logic [QAW-1:0]  rd_reg, rd_next;
    logic [QAW:0]    cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign do_push = push && (cnt_reg != (QAW+1)'(QDEPTH));
    assign do_pop  = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_item;
    end

    assign pop_item     = mem_reg[rd_reg];
    assign status.full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign status.push  = do_push;
    assign status.pop   = do_pop;

endmodule

@@ sv/eavr_back.sv @@
// back: direction cosine matrix build and matrix-vector product with saturation
// depends on eavr_pkg
module eavr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  eavr_pkg::trig_item_t  in_item,
    output logic                  out_valid,
    output eavr_pkg::out_item_t   out_item
);
    import eavr_pkg::*;

    localparam int PW = 2 * TW;            // q14 products
    localparam int TP = 3 * TW;            // triple products
    localparam int AW = MW + VECTOR_WIDTH + 3;

    function automatic logic signed [MW-1:0] r14(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        begin
            t = (p + PW'(8192)) >>> 14;
            return t[MW-1:0];
        end
    endfunction

    function automatic logic signed [MW-1:0] r28(input logic signed [TP-1:0] p);
        logic signed [TP-1:0] t;
        begin
            t = (p + TP'(134217728)) >>> 28;
            return t[MW-1:0];
        end
    endfunction

    // stage 1: pair products
    logic                 v1_reg;
    trig_item_t           t1_reg;
    logic signed [PW-1:0] sxsy_reg, cxcz_reg, sysz_reg, cysz_reg, szcx_reg;
    logic signed [PW-1:0] sxsz_reg, sxcz_reg, sxcy_reg, cxcy_reg, cycz_reg;

    // stage 2: triple products and q14 terms
    logic                 v2_reg;
    trig_item_t           t2_reg;
    logic signed [TP-1:0] sxsycz_reg, sycxcz_reg, sxsysz_reg, syszcx_reg;
    logic signed [MW-1:0] a0_reg, a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a7_reg, a8_reg;

    // stage 3: matrix
    logic                 v3_reg;
    trig_item_t           t3_reg;
    logic signed [MW-1:0] m_reg [9];

    // stage 4: products with vector
    logic                 v4_reg;
    logic signed [AW-1:0] p_reg [9];

    // stage 5: output
    logic                 v5_reg;
    out_item_t            o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= in_item;
        sxsy_reg <= in_item.sx * in_item.sy;
        cxcz_reg <= in_item.cx * in_item.cz;
        sysz_reg <= in_item.sy * in_item.sz;
        cysz_reg <= in_item.cy * in_item.sz;
        szcx_reg <= in_item.sz * in_item.cx;
        sxsz_reg <= in_item.sx * in_item.sz;
        sxcz_reg <= in_item.sx * in_item.cz;
        sxcy_reg <= in_item.sx * in_item.cy;
        cxcy_reg <= in_item.cx * in_item.cy;
        cycz_reg <= in_item.cy * in_item.cz;
    end

    always_ff @(posedge clk)
    begin
        t2_reg     <= t1_reg;
        sxsycz_reg <= TP'(sxsy_reg) * TP'(t1_reg.cz);
        sycxcz_reg <= TP'(cxcz_reg) * TP'(t1_reg.sy);
        sxsysz_reg <= TP'(sxsy_reg) * TP'(t1_reg.sz);
        syszcx_reg <= TP'(sysz_reg) * TP'(t1_reg.cx);
        a0_reg     <= r14(cycz_reg);
        a1_reg     <= r14(szcx_reg);
        a2_reg     <= r14(sxsz_reg);
        a3_reg     <= r14(cysz_reg);
        a4_reg     <= r14(cxcz_reg);
        a5_reg     <= r14(sxcz_reg);
        a7_reg     <= r14(sxcy_reg);
        a8_reg     <= r14(cxcy_reg);
    end

    always_ff @(posedge clk)
    begin
        t3_reg   <= t2_reg;
        m_reg[0] <= a0_reg;
        m_reg[1] <= a1_reg + r28(sxsycz_reg);
        m_reg[2] <= -a2_reg + r28(sycxcz_reg);
        m_reg[3] <= -a3_reg;
        m_reg[4] <= a4_reg - r28(sxsysz_reg);
        m_reg[5] <= -a5_reg - r28(syszcx_reg);
        m_reg[6] <= -MW'(t2_reg.sy);
        m_reg[7] <= a7_reg;
        m_reg[8] <= a8_reg;
    end

    // products laid out by output row; op picks matrix or transpose
    always_ff @(posedge clk)
    begin
        logic signed [VECTOR_WIDTH-1:0] v [3];
        v[0] = t3_reg.vec_x;
        v[1] = t3_reg.vec_y;
        v[2] = t3_reg.vec_z;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p_reg[3*i+j] <= AW'((t3_reg.op == OP_EARTH) ? m_reg[3*j+i] : m_reg[3*i+j])
                                * AW'(v[j]);
    end

    function automatic logic signed [VECTOR_WIDTH-1:0] sat(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        begin
            r  = (a + AW'(8192)) >>> 14;
            hi = AW'({1'b0, {(VECTOR_WIDTH-1){1'b1}}});
            lo = -hi - AW'(1);
            if (r > hi)
                r = hi;
            else if (r < lo)
                r = lo;
            return r[VECTOR_WIDTH-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        o_reg.out_x <= sat(p_reg[0] + p_reg[1] + p_reg[2]);
        o_reg.out_y <= sat(p_reg[3] + p_reg[4] + p_reg[5]);
        o_reg.out_z <= sat(p_reg[6] + p_reg[7] + p_reg[8]);
    end

    assign out_valid = v5_reg;
    assign out_item  = o_reg;

endmodule

@@ sv/euler_angle_vector_rotation.sv @@
// euler_angle_vector_rotation top: cordic front, fifo, matrix back
// depends on eavr_pkg, eavr_front, eavr_queue, eavr_back
//
//  channel   signals                     handshake
//  command   start, busy, cmd            taken when start && !busy
//  result    done, result                one cycle pulse, no stall
//
// one item per cycle sustained; the cordic pipeline holds 24 rotation stages plus
// fold and round, then comes the fifo, then the matrix pipeline (pair products,
// triple products, matrix, vector products, output). busy is never raised as the back pipeline cannot stall.
// reset clears only the valid bits and the fifo pointers and count.
module euler_angle_vector_rotation (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  eavr_pkg::in_item_t   cmd,
    output logic                 done,
    output eavr_pkg::out_item_t  result
);
    import eavr_pkg::*;

    logic        f_valid;
    trig_item_t  f_item;
    trig_item_t  q_item;
    q_status_t   q_st;
    logic        accept;

    assign busy   = q_st.full;
    assign accept = start && !busy;

    eavr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (cmd),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    eavr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .pop       (!q_st.empty),
        .pop_item  (q_item),
        .status    (q_st)
    );

    eavr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_st.pop),
        .in_item   (q_item),
        .out_valid (done),
        .out_item  (result)
    );

    // fifo drains every cycle so it never fills
    a_never_full: assert property (@(posedge clk) disable iff (!rst_n) !q_st.full)
        else $error("queue filled");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> q_st.push)
        else $error("front item dropped");
    a_pop_next: assert property (@(posedge clk) disable iff (!rst_n)
        q_st.push |=> q_st.pop)
        else $error("queue not drained");

endmodule

@@ tb/sv/euler_angle_vector_rotation_tb.sv @@
`timescale 1ns / 1ps
// testbench for euler_angle_vector_rotation: euler-angle rotation of a vector,
// checked against an in-bench fixed-point cordic and matrix predictor
// depends on eavr_pkg and the euler_angle_vector_rotation rtl
module euler_angle_vector_rotation_tb;
    import eavr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 64;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  cmd;
    logic      done;
    out_item_t result;

    out_item_t rotated_q[$];
    int        error_count;
    int        idle_cycles;

    euler_angle_vector_rotation u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    const longint atan_lut[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    // sine and cosine in q1.14 of a q2.13 angle
    function automatic void trig_of(input logic signed [ANGLE_WIDTH-1:0] ang,
                                    output longint s, output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = longint'(ang) * (longint'(1) <<< (30 - (ANGLE_WIDTH - 3)));
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z > longint'(ANG_HALF_PI))
        begin
            z = z - longint'(ANG_PI);
            flip = 1'b1;
        end
        else if (z < -longint'(ANG_HALF_PI))
        begin
            z = z + longint'(ANG_PI);
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_lut[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_lut[i];
            end
            x = nx;
        end
        c = clamp_unit(rnd_shift(x, 16));
        s = clamp_unit(rnd_shift(y, 16));
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic out_item_t rotate_vector(input in_item_t it);
        longint sx, cx, sy, cy, sz, cz, acc, r;
        longint m[9];
        longint v[3];
        longint lim;
        logic signed [VECTOR_WIDTH-1:0] comp[3];
        out_item_t o;
        lim = longint'(1) <<< (VECTOR_WIDTH - 1);
        v[0] = it.vec_x;
        v[1] = it.vec_y;
        v[2] = it.vec_z;
        trig_of(it.angle_x, sx, cx);
        trig_of(it.angle_y, sy, cy);
        trig_of(it.angle_z, sz, cz);
        m[0] = rnd_shift(cy * cz, 14);
        m[1] = rnd_shift(sz * cx, 14) + rnd_shift(sx * sy * cz, 28);
        m[2] = -rnd_shift(sx * sz, 14) + rnd_shift(sy * cx * cz, 28);
        m[3] = -rnd_shift(sz * cy, 14);
        m[4] = rnd_shift(cx * cz, 14) - rnd_shift(sx * sy * sz, 28);
        m[5] = -rnd_shift(sx * cz, 14) - rnd_shift(sy * sz * cx, 28);
        m[6] = -sy;
        m[7] = rnd_shift(sx * cy, 14);
        m[8] = rnd_shift(cx * cy, 14);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += ((it.op == OP_EARTH) ? m[3 * j + i] : m[3 * i + j]) * v[j];
            r = rnd_shift(acc, 14);
            if (r > lim - 1)
                r = lim - 1;
            if (r < -lim)
                r = -lim;
            comp[i] = r[VECTOR_WIDTH-1:0];
        end
        o.out_x = comp[0];
        o.out_y = comp[1];
        o.out_z = comp[2];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (rotated_q.size() == 0)
                report_mismatch("unexpected item", 0, 0);
            else
            begin
                want = rotated_q.pop_front();
                if (result.out_x !== want.out_x)
                    report_mismatch("out_x", result.out_x, want.out_x);
                if (result.out_y !== want.out_y)
                    report_mismatch("out_y", result.out_y, want.out_y);
                if (result.out_z !== want.out_z)
                    report_mismatch("out_z", result.out_z, want.out_z);
            end
        end
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    int burst_left;

    task automatic send_item(input in_item_t it);
        // random gap between bursts
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rotated_q.push_back(rotate_vector(it));
        @(negedge clk);
    endtask

    function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return ANGLE_WIDTH'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            default: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
        endcase
    endfunction

    function automatic logic signed [VECTOR_WIDTH-1:0] rand_vec();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            1: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            default: return VECTOR_WIDTH'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        in_item_t it;
        logic signed [ANGLE_WIDTH-1:0] angs[6] = '{16'sd0, 16'sh7fff, 16'sh8000,
            16'sd12868, -16'sd12868, 16'sd25736};
        for (int k = 0; k < 12; k++)
        begin
            it.op      = k[0] ? OP_EARTH : OP_BODY;
            it.vec_x   = (k % 3 == 0) ? 24'sh7fffff : 24'sh800000;
            it.vec_y   = (k % 3 == 1) ? 24'sh7fffff : 24'sd4096;
            it.vec_z   = (k % 4 == 2) ? 24'sh800000 : 24'sh7fffff;
            it.angle_x = angs[k % 6];
            it.angle_y = angs[(k + 2) % 6];
            it.angle_z = angs[(k + 4) % 6];
            send_item(it);
        end
        // identity rotation and all-ones patterns
        it = '0;
        it.vec_x = 24'sd4096;
        send_item(it);
        it = '1;
        send_item(it);
    endtask

    task automatic test_random(input int n);
        in_item_t it;
        for (int k = 0; k < n; k++)
        begin
            it.op      = $urandom_range(0, 1) ? OP_EARTH : OP_BODY;
            it.vec_x   = rand_vec();
            it.vec_y   = rand_vec();
            it.vec_z   = rand_vec();
            it.angle_x = rand_angle();
            it.angle_y = rand_angle();
            it.angle_z = rand_angle();
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        error_count = 0;
        idle_cycles = 0;
        burst_left  = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(1440);
        start <= 1'b0;
        wait (rotated_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
